FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int TAG_W      = 16;
  localparam int COST_W     = 32;
  localparam int LEVEL_W    = 8;
  localparam int OPCOST_W   = 29;
  localparam int LIMIT_W    = 33;

  localparam logic [OPCOST_W-1:0] OPCOST_RESET = 29'd164;
  localparam logic [LIMIT_W-1:0]  CHEAP_FACTOR = 33'd10;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(OPCOST_RESET) * CHEAP_FACTOR;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COST_W-1:0]  cost;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_one;
    logic empty;
  } dp_stat_t;

  // True when a new entry belongs behind a held one: equal keys keep arrival order.
  function automatic logic goes_after(input entry_t fresh, input entry_t held);
    logic after;
    if (fresh.level != held.level) begin
      after = fresh.level > held.level;
    end else begin
      after = fresh.cost >= held.cost;
    end
    return after;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sts_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sts_item_if;
  logic        valid;
  logic        ready;
  logic [15:0] item_tag;
  logic [31:0] item_cost;
  logic [7:0]  item_level;
  logic        leak_proof;
  logic        final_item;

  modport source (output valid, output item_tag, output item_cost, output item_level,
                  output leak_proof, output final_item, input ready);
  modport sink (input valid, input item_tag, input item_cost, input item_level,
                input leak_proof, input final_item, output ready);
endinterface

interface sts_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] sorted_tag;
  logic        final_result;
  logic        overflowed;

  modport source (output valid, output sorted_tag, output final_result,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_tag, input final_result,
                input overflowed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sts_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_dp import sts_pkg::*; #(
  parameter int MAX_ITEMS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [OPCOST_W-1:0] cfg_wdata,
  input  wire logic [TAG_W-1:0]    item_tag,
  input  wire logic [COST_W-1:0]   item_cost,
  input  wire logic [LEVEL_W-1:0]  item_level,
  input  wire logic                leak_proof,
  input  wire ctl_cmd_t            cmd,
  output dp_stat_t                 stat,
  output logic [TAG_W-1:0]         sorted_tag,
  output logic                     final_result,
  output logic                     overflowed
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [LIMIT_W-1:0] limit;
  logic [CW-1:0]      count;
  logic               drop;
  entry_t             row [MAX_ITEMS];
  entry_t             ins [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] ga;
  entry_t             fresh;
  logic               full;

  assign full = (count == CW'(MAX_ITEMS));

  always_comb begin
    fresh.tag   = item_tag;
    fresh.cost  = item_cost;
    fresh.level = item_level;
    if (leak_proof && ({1'b0, item_cost} < limit)) begin
      fresh.level = '0;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign ga[i] = (CW'(i) < count) && goes_after(fresh, row[i]);

    if (i == 0) begin : g_head
      assign ins[i] = ga[i] ? row[i] : fresh;
    end else begin : g_body
      assign ins[i] = ga[i] ? row[i] : (ga[i-1] ? fresh : row[i-1]);
    end

    always_ff @(posedge clk) begin
      if (cmd.load && !full) begin
        row[i] <= ins[i];
      end else if (cmd.shift) begin
        row[i] <= (i < MAX_ITEMS - 1) ? row[(i < MAX_ITEMS - 1) ? i + 1 : i] : row[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      count <= '0;
      drop  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= LIMIT_W'(cfg_wdata) * CHEAP_FACTOR;
      end
      priority if (cmd.finish) begin
        count <= '0;
        drop  <= 1'b0;
      end else if (cmd.load) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end else if (cmd.shift) begin
        count <= count - CW'(1);
      end
    end
  end

  assign stat.last_one = (count == CW'(1));
  assign stat.empty    = (count == '0);
  assign sorted_tag    = row[0].tag;
  assign final_result  = stat.last_one;
  assign overflowed    = drop;

endmodule

`default_nettype wire

FILE: hw/rtl/sts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sts_ctrl import sts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_final,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
        if (in_valid && in_final) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid  = 1'b1;
        cmd.shift  = out_ready;
        cmd.finish = out_ready && stat.last_one;
        if (out_ready && stat.last_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPL(a_sides_apart, clk, rst, in_ready, !out_valid, "input and output open together")
  `ASSERT_IMPL(a_drain_nonempty, clk, rst, state == ST_DRAIN, !stat.empty, "draining an empty row")
  `ASSERT_NEXT(a_final_drains, clk, rst, in_valid && in_ready && in_final, state == ST_DRAIN, "final item did not start the run")
  `ASSERT_NEXT(a_finish_idle, clk, rst, cmd.finish, state == ST_IDLE && stat.empty, "run did not end cleanly")

endmodule

`default_nettype wire

FILE: hw/rtl/stable_two_key_insertion_sorter.sv
// Channel   Direction  Payload                                             Accepted when
// in_ch     in         item_tag, item_cost, item_level, leak_proof, final  valid && ready
// out_ch    out        sorted_tag, final_result, overflowed                valid && ready
// cfg       in         cfg_wdata (operator_cost)                           cfg_we
//
// Items are placed by a row of compare cells, one per cycle while collecting.
// A final item starts a run of one result per stored entry, one per cycle at most,
// shifted out of the head cell; no item is taken until the run ends.
// Synchronous reset empties the row at once; no clearing pass is needed.
// A stall on the output holds the head cell and the run simply waits.
`timescale 1ns / 1ps
`default_nettype none

module stable_two_key_insertion_sorter import sts_pkg::*; #(
  parameter int MAX_ITEMS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  sts_item_if.sink                 in_ch,
  sts_result_if.source             out_ch,
  input  wire logic                cfg_we,
  input  wire logic [OPCOST_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_final  (in_ch.final_item),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sts_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_tag     (in_ch.item_tag),
    .item_cost    (in_ch.item_cost),
    .item_level   (in_ch.item_level),
    .leak_proof   (in_ch.leak_proof),
    .cmd          (cmd),
    .stat         (stat),
    .sorted_tag   (out_ch.sorted_tag),
    .final_result (out_ch.final_result),
    .overflowed   (out_ch.overflowed)
  );

endmodule

`default_nettype wire

FILE: bench/tb_stable_two_key_insertion_sorter.sv
`timescale 1ns / 1ps

module tb_stable_two_key_insertion_sorter;
  import sts_pkg::*;

  localparam int DEPTH = 32;
  localparam int PLAN_ROWS = 15;
  localparam int PHASE_ITEMS = 46;
  localparam int HOLD_CYCLES = 150;
  localparam logic [OPCOST_W-1:0] OPCOST_TOP = 29'd429496729;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COST_W-1:0]  cost;
    logic [LEVEL_W-1:0] level;
    logic               leak;
    logic               last;
  } clause_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             ovf;
  } ranked_tag_t;

  typedef struct packed {
    clause_t          item;
    logic             typed;
    logic [TAG_W-1:0] want_tag;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [OPCOST_W-1:0] cfg_wdata;

  sts_item_if   item_ch();
  sts_result_if result_ch();

  stable_two_key_insertion_sorter #(.MAX_ITEMS(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (item_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  entry_t              sorted_q[$];
  logic                lost_any = 1'b0;
  logic [OPCOST_W-1:0] op_cost = OPCOST_RESET;
  ranked_tag_t         due_q[$];

  int  errors = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  send_calm = 0;
  int  take_calm = 0;
  bit  held_off = 1'b0;

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  // Places one clause in the ordered list, or drops it when the list is full; a last clause releases the whole list.
  function automatic int file_clause(input clause_t c);
    entry_t              e;
    logic [LIMIT_W-1:0]  cheap_limit;
    int                  pos;
    int                  n;
    cheap_limit = LIMIT_W'(op_cost) * CHEAP_FACTOR;
    e.tag   = c.tag;
    e.cost  = c.cost;
    e.level = c.level;
    if (c.leak && LIMIT_W'(c.cost) < cheap_limit) begin
      e.level = '0;
    end
    if (sorted_q.size() < DEPTH) begin
      pos = sorted_q.size();
      while (pos > 0 &&
             {e.level, e.cost} < {sorted_q[pos-1].level, sorted_q[pos-1].cost}) begin
        pos--;
      end
      sorted_q.insert(pos, e);
    end else begin
      lost_any = 1'b1;
    end
    n = 0;
    if (c.last) begin
      n = sorted_q.size();
      for (int k = 0; k < n; k++) begin
        due_q.push_back('{sorted_q[k].tag, k == n - 1, lost_any});
      end
      sorted_q.delete();
      lost_any = 1'b0;
    end
    return n;
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    longint             near;
    logic [LIMIT_W-1:0] cheap_limit;
    logic [COST_W-1:0]  cost;
    cheap_limit = LIMIT_W'(op_cost) * CHEAP_FACTOR;
    case ($urandom_range(0, 3))
      0: begin
        cost = $urandom();
      end
      1: begin
        near = longint'(cheap_limit) + longint'($urandom_range(0, 4)) - 64'sd2;
        if (near < 0) begin
          near = 0;
        end
        if (near > 64'sh0_FFFF_FFFF) begin
          near = 64'sh0_FFFF_FFFF;
        end
        cost = near[31:0];
      end
      2: begin
        cost = COST_W'($urandom_range(0, 7));
      end
      default: begin
        cost = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
    endcase
    return cost;
  endfunction

  task automatic offer(input clause_t c, output int n);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 24) == 0) begin
        send_calm = $urandom_range(8, 24);
      end
    end
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.item_tag   <= c.tag;
    item_ch.item_cost  <= c.cost;
    item_ch.item_level <= c.level;
    item_ch.leak_proof <= c.leak;
    item_ch.final_item <= c.last;
    do @(posedge clk); while (!item_ch.ready);
    n = file_clause(c);
    items_sent++;
  endtask

  task automatic write_opcost(input logic [OPCOST_W-1:0] v);
    while (due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    op_cost = v;
  endtask

  initial begin : stimulus
    plan_row_t           plan [PLAN_ROWS];
    logic [OPCOST_W-1:0] phase_cost [4];
    clause_t             c;
    int                  n;
    int                  len;
    int                  budget;
    bit                  first;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    item_ch.valid      = 1'b0;
    item_ch.item_tag   = '0;
    item_ch.item_cost  = '0;
    item_ch.item_level = '0;
    item_ch.leak_proof = 1'b0;
    item_ch.final_item = 1'b0;

    plan = '{
      '{'{16'hFFFF, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1}, 1'b1, 16'hFFFF},
      '{'{16'h0000, 32'h0,         8'd0,   1'b0, 1'b1}, 1'b1, 16'h0000},
      '{'{16'h0001, 32'd1639,      8'd200, 1'b1, 1'b1}, 1'b1, 16'h0001},
      '{'{16'h0010, 32'd1639,      8'd200, 1'b1, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0011, 32'd1640,      8'd200, 1'b1, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0012, 32'd5000,      8'd3,   1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0013, 32'd5000,      8'd3,   1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0014, 32'd100,       8'd3,   1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0015, 32'd0,         8'd0,   1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0016, 32'd1639,      8'd0,   1'b1, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0017, 32'd5000,      8'd3,   1'b1, 1'b1}, 1'b0, 16'h0},
      '{'{16'hAAAA, 32'h8000_0000, 8'h55,  1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h5555, 32'h7FFF_FFFF, 8'hAA,  1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{16'h0F0F, 32'h8000_0000, 8'h55,  1'b1, 1'b0}, 1'b0, 16'h0},
      '{'{16'hF0F0, 32'd1,         8'd255, 1'b1, 1'b1}, 1'b0, 16'h0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].item, n);
      if (plan[i].typed) begin
        repeat (n) void'(due_q.pop_back());
        due_q.push_back('{plan[i].want_tag, 1'b1, 1'b0});
      end
    end
    item_ch.valid <= 1'b0;

    phase_cost = '{29'd0, OPCOST_TOP, OPCOST_W'($urandom_range(1, 4000)),
                   OPCOST_W'($urandom_range(0, 429496729))};
    foreach (phase_cost[p]) begin
      write_opcost(phase_cost[p]);
      budget = items_sent + PHASE_ITEMS;
      first = 1'b1;
      while (items_sent < budget) begin
        // The opening lists of two phases overrun the store, so their last clauses are dropped.
        if (first && p == 0) begin
          len = DEPTH + 1;
        end else if (first && p == 2) begin
          len = DEPTH + 2;
        end else if ($urandom_range(0, 11) == 0) begin
          len = $urandom_range(DEPTH - 2, DEPTH + 2);
        end else begin
          len = $urandom_range(1, 8);
        end
        first = 1'b0;
        for (int k = 0; k < len; k++) begin
          c.tag   = TAG_W'($urandom_range(0, 65535));
          c.cost  = pick_cost();
          c.level = $urandom_range(0, 1) ? LEVEL_W'($urandom_range(0, 3))
                                         : LEVEL_W'($urandom_range(0, 255));
          c.leak  = 1'($urandom_range(0, 1));
          c.last  = (k == len - 1);
          offer(c, n);
        end
      end
      item_ch.valid <= 1'b0;
    end

    while (due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : drain
    ranked_tag_t want;
    int          stall;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // One long hold-off stalls the output, so the sorter refuses further items while a run waits.
      if (!held_off && results_seen >= 20) begin
        stall = HOLD_CYCLES;
        held_off = 1'b1;
      end else if (take_calm > 0) begin
        stall = 0;
        take_calm--;
      end else begin
        stall = $urandom_range(0, 3);
        if ($urandom_range(0, 24) == 0) begin
          take_calm = $urandom_range(8, 24);
        end
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      results_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("result with tag %0h arrived with nothing due",
                         result_ch.sorted_tag));
      end else begin
        want = due_q.pop_front();
        if (result_ch.sorted_tag !== want.tag) begin
          report($sformatf("sorted_tag %0h, expected %0h", result_ch.sorted_tag, want.tag));
        end
        if (result_ch.final_result !== want.last) begin
          report($sformatf("final_result %0b, expected %0b", result_ch.final_result, want.last));
        end
        if (result_ch.overflowed !== want.ovf) begin
          report($sformatf("overflowed %0b, expected %0b", result_ch.overflowed, want.ovf));
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
